### rtl/werl_pkg.sv
package werl_pkg;

  localparam int NUM_ACTIONS_DEF = 64;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int NOW_WIDTH       = 63;
  localparam int ACT_WIDTH       = 6;
  localparam int LIMIT_WIDTH     = 31;
  localparam int WSEC_WIDTH      = 32;
  localparam int CFG_INDEX_WIDTH = 8;
  localparam int CFG_DATA_WIDTH  = 32;

  // tag kept next to each count so a window restart clears without a sweep unless the tag wraps
  localparam int EPOCH_WIDTH = 8;

  localparam logic [NOW_WIDTH-1:0] NS_PER_SEC = 63'd1000000000;
  // (86400 + 1) seconds in ns: restart threshold for the default window
  localparam logic [NOW_WIDTH-1:0] THR_RESET  = 63'd86401000000000;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OVERALL_LIMIT  = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_SECONDS = 8'd1;

  typedef enum logic [1:0] {
    CAUSE_ALLOWED = 2'd0,
    CAUSE_CLOCK   = 2'd1,
    CAUSE_ACTION  = 2'd2,
    CAUSE_OVERALL = 2'd3
  } cause_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EVAL,
    ST_COUNT,
    ST_OVERALL,
    ST_OUT
  } state_t;

endpackage

### rtl/werl_if.sv
interface werl_req_if;
  import werl_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [NOW_WIDTH-1:0]   now_ns;
  logic [ACT_WIDTH-1:0]   action_id;
  logic [LIMIT_WIDTH-1:0] per_action_limit;
  modport source (output valid, now_ns, action_id, per_action_limit, input ready);
  modport sink   (input valid, now_ns, action_id, per_action_limit, output ready);
endinterface

interface werl_res_if;
  logic       valid;
  logic       ready;
  logic       limited;
  logic [1:0] cause;
  modport source (output valid, limited, cause, input ready);
  modport sink   (input valid, limited, cause, output ready);
endinterface

interface werl_cfg_if;
  import werl_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/werl_mem.sv
module werl_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/werl_thresh.sv
module werl_thresh (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [werl_pkg::WSEC_WIDTH-1:0]   window_seconds,
  output logic [werl_pkg::NOW_WIDTH-1:0]    thresh,
  output logic                              busy
);

  import werl_pkg::*;

  // shift-add multiply: thresh = (window_seconds + 1) * 1e9, one bit per cycle
  logic [WSEC_WIDTH:0]    mcand;
  logic [NOW_WIDTH-1:0]   addend;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THR_RESET;
      mcand  <= '0;
    end else if (start) begin
      thresh <= '0;
      mcand  <= (WSEC_WIDTH+1)'(window_seconds) + 1'b1;
      addend <= NS_PER_SEC;
    end else if (busy) begin
      if (mcand[0]) begin
        thresh <= thresh + addend;
      end
      mcand  <= mcand >> 1;
      addend <= addend << 1;
    end
  end

  assign busy = |mcand;

endmodule

### rtl/windowed_event_rate_limiter.sv
// channel  dir  beat contents
// req      in   now_ns, action_id, per_action_limit
// res      out  limited, cause
// cfg      in   index (0 overall_limit, 1 window_seconds), data
//
// an item passes accept, evaluate, count update, overall update and result register; the
// overall step drops out when it does not apply, both updates for a clock before the window.
// a window restart that wraps the epoch tag runs a sweep over all NUM_ACTIONS entries.
// after reset a clearing pass over all NUM_ACTIONS entries runs before req is taken.
// a window_seconds beat holds req off in its own cycle and while the multiply runs.
// a waiting result holds the next one in the evaluation sequence.
module windowed_event_rate_limiter #(
  parameter int NUM_ACTIONS = werl_pkg::NUM_ACTIONS_DEF,
  parameter int COUNT_WIDTH = werl_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  werl_req_if.sink    req,
  werl_res_if.source  res,
  werl_cfg_if.sink    cfg
);

  import werl_pkg::*;

  localparam int AW = $clog2(NUM_ACTIONS);
  localparam int MW = EPOCH_WIDTH + COUNT_WIDTH;

  state_t state, state_next;

  logic [AW-1:0]          sweep_idx;
  logic                   sweep_item;
  logic [EPOCH_WIDTH-1:0] epoch;
  logic [NOW_WIDTH-1:0]   window_start;
  logic [COUNT_WIDTH-1:0] overall_count;
  logic [LIMIT_WIDTH-1:0] overall_limit;

  logic [NOW_WIDTH-1:0]   now_q;
  logic [ACT_WIDTH-1:0]   act_q;
  logic [LIMIT_WIDTH-1:0] limit_q;
  logic                   in_range_q;
  logic                   before_q;
  logic [NOW_WIDTH-1:0]   diff_q;
  logic                   restart_q;
  cause_t                 cause_q, cause_next;

  logic                   res_valid;
  logic                   res_limited;
  cause_t                 res_cause;

  logic                   thr_start;
  logic [NOW_WIDTH-1:0]   thresh;
  logic                   thr_busy;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [MW-1:0]          mem_wdata;
  logic                   mem_re;
  logic [MW-1:0]          mem_rdata;

  logic                   req_fire;
  logic                   cfg_fire;
  logic                   restart;
  logic [EPOCH_WIDTH-1:0] epoch_inc;
  logic [COUNT_WIDTH-1:0] cnt_eff;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic [COUNT_WIDTH-1:0] ov_new;
  logic                   out_free;

  assign req.ready = (state == ST_IDLE) && !thr_busy && !thr_start;
  assign req_fire  = req.valid && req.ready;
  assign cfg.ready = !thr_busy;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign thr_start = cfg_fire && (cfg.index == CFG_WINDOW_SECONDS);

  assign res.valid   = res_valid;
  assign res.limited = res_limited;
  assign res.cause   = res_cause;
  assign out_free    = !res_valid || res.ready;

  werl_thresh u_thresh (
    .clk            (clk),
    .rst            (rst),
    .start          (thr_start),
    .window_seconds (cfg.data[WSEC_WIDTH-1:0]),
    .thresh         (thresh),
    .busy           (thr_busy)
  );

  werl_mem #(
    .DEPTH (NUM_ACTIONS),
    .WIDTH (MW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (AW'(req.action_id)),
    .rdata (mem_rdata)
  );

  assign mem_re    = req_fire;
  assign restart   = diff_q >= thresh;
  assign epoch_inc = epoch + 1'b1;

  // an entry tagged with an older epoch belongs to a cleared window
  assign cnt_eff = (restart_q || (mem_rdata[COUNT_WIDTH +: EPOCH_WIDTH] != epoch)) ?
                   '0 : mem_rdata[COUNT_WIDTH-1:0];
  assign cnt_new = (cnt_eff == '1) ? cnt_eff : cnt_eff + 1'b1;
  assign ov_new  = (overall_count == '1) ? overall_count : overall_count + 1'b1;

  always_comb begin
    state_next = state;
    cause_next = cause_q;
    mem_we     = 1'b0;
    mem_waddr  = AW'(act_q);
    mem_wdata  = {epoch, cnt_new};
    case (state)
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_idx;
        mem_wdata = {epoch, {COUNT_WIDTH{1'b0}}};
        if (sweep_idx == AW'(NUM_ACTIONS - 1)) begin
          state_next = sweep_item ? ST_COUNT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_fire) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (before_q) begin
          cause_next = CAUSE_CLOCK;
          state_next = ST_OUT;
        end else if (restart && (epoch_inc == '0)) begin
          state_next = ST_SWEEP;
        end else begin
          state_next = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (!in_range_q) begin
          cause_next = CAUSE_ACTION;
          state_next = ST_OUT;
        end else begin
          mem_we = 1'b1;
          if (32'(cnt_new) > 32'(limit_q)) begin
            cause_next = CAUSE_ACTION;
            state_next = ST_OUT;
          end else if (overall_limit != '0) begin
            state_next = ST_OVERALL;
          end else begin
            cause_next = CAUSE_ALLOWED;
            state_next = ST_OUT;
          end
        end
      end
      ST_OVERALL: begin
        cause_next = (32'(ov_new) > 32'(overall_limit)) ? CAUSE_OVERALL : CAUSE_ALLOWED;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_idx     <= '0;
      sweep_item    <= 1'b0;
      epoch         <= '0;
      window_start  <= '0;
      overall_count <= '0;
      overall_limit <= '0;
      restart_q     <= 1'b0;
      cause_q       <= CAUSE_ALLOWED;
      res_valid     <= 1'b0;
    end else begin
      if (cfg_fire && (cfg.index == CFG_OVERALL_LIMIT)) begin
        overall_limit <= cfg.data[LIMIT_WIDTH-1:0];
      end
      cause_q <= cause_next;

      case (state)
        ST_SWEEP: begin
          if (sweep_idx == AW'(NUM_ACTIONS - 1)) begin
            sweep_idx <= '0;
          end else begin
            sweep_idx <= sweep_idx + 1'b1;
          end
        end
        ST_EVAL: begin
          restart_q  <= !before_q && restart;
          sweep_item <= 1'b1;
          if (!before_q && restart) begin
            window_start  <= now_q;
            overall_count <= '0;
            epoch         <= epoch_inc;
          end
        end
        ST_OVERALL: begin
          overall_count <= ov_new;
        end
        default: begin
        end
      endcase

      if (state == ST_OUT && out_free) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // item payload, no reset needed
  always_ff @(posedge clk) begin
    if (req_fire) begin
      now_q      <= req.now_ns;
      act_q      <= req.action_id;
      limit_q    <= req.per_action_limit;
      in_range_q <= 32'(req.action_id) < 32'(NUM_ACTIONS);
      before_q   <= req.now_ns < window_start;
      diff_q     <= req.now_ns - window_start;
    end
    if (state == ST_OUT && out_free) begin
      res_limited <= cause_q != CAUSE_ALLOWED;
      res_cause   <= cause_q;
    end
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import werl_pkg::*;

  localparam logic [NOW_WIDTH-1:0]   MAX_NOW      = {NOW_WIDTH{1'b1}};
  localparam logic [LIMIT_WIDTH-1:0] MAX_LIMIT    = {LIMIT_WIDTH{1'b1}};
  localparam logic [WSEC_WIDTH-1:0]  MAX_WINDOW   = {WSEC_WIDTH{1'b1}};
  localparam logic [WSEC_WIDTH-1:0]  DAY_SECONDS  = 60 * 60 * 24;
  localparam int                     CYCLE_LIMIT  = 400000;
  localparam int                     PHASE_ITEMS  = 50;
  localparam int                     PHASE_COUNT  = 9;

  // directed time points
  localparam logic [NOW_WIDTH-1:0] T_DAY   = 63'd86400 * NS_PER_SEC;
  localparam logic [NOW_WIDTH-1:0] T_RST1  = 63'd86401 * NS_PER_SEC;
  localparam logic [NOW_WIDTH-1:0] T_RST2  = 63'd86403 * NS_PER_SEC;
  localparam logic [NOW_WIDTH-1:0] T_EDGE  = T_RST2 + 63'hFFFF_FFFF * NS_PER_SEC
                                             + 63'd999_999_999;
  localparam logic [NOW_WIDTH-1:0] T_RST3  = T_RST2 + 63'h1_0000_0000 * NS_PER_SEC;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_TRICKLE} ready_mode_t;

  class rate_scoreboard;
    typedef struct packed {
      logic   limited;
      cause_t cause;
    } verdict_t;

    logic [LIMIT_WIDTH-1:0]     overall_limit;
    logic [WSEC_WIDTH-1:0]      window_secs;
    logic [NOW_WIDTH-1:0]       win_start;
    logic [COUNT_WIDTH_DEF-1:0] act_count [NUM_ACTIONS_DEF];
    logic [COUNT_WIDTH_DEF-1:0] total_count;
    verdict_t                   verdicts [$];
    longint                     stamps [$];
    int                         errors;

    function new();
      overall_limit = '0;
      window_secs   = DAY_SECONDS;
      win_start     = '0;
      total_count   = '0;
      foreach (act_count[i]) act_count[i] = '0;
      errors = 0;
    endfunction

    function logic [COUNT_WIDTH_DEF-1:0] bump(logic [COUNT_WIDTH_DEF-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    function void write_reg(logic [CFG_INDEX_WIDTH-1:0] index,
                            logic [CFG_DATA_WIDTH-1:0] data);
      if (index == CFG_OVERALL_LIMIT) overall_limit = data[LIMIT_WIDTH-1:0];
      else if (index == CFG_WINDOW_SECONDS) window_secs = data;
    endfunction

    function void note_request(logic [NOW_WIDTH-1:0] now, logic [ACT_WIDTH-1:0] act,
                               logic [LIMIT_WIDTH-1:0] lim, longint stamp);
      verdict_t v;
      v.limited = 1'b0;
      v.cause   = CAUSE_ALLOWED;
      if (now < win_start) begin
        v.limited = 1'b1;
        v.cause   = CAUSE_CLOCK;
      end else begin
        // restart only when strictly more whole seconds than the window
        if ((now - win_start) / NS_PER_SEC > window_secs) begin
          foreach (act_count[i]) act_count[i] = '0;
          total_count = '0;
          win_start   = now;
        end
        act_count[act] = bump(act_count[act]);
        if (act_count[act] > lim) begin
          v.limited = 1'b1;
          v.cause   = CAUSE_ACTION;
        end else if (overall_limit != 0) begin
          total_count = bump(total_count);
          if (total_count > overall_limit) begin
            v.limited = 1'b1;
            v.cause   = CAUSE_OVERALL;
          end
        end
      end
      verdicts.push_back(v);
      stamps.push_back(stamp);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_result(logic limited, logic [1:0] cause, longint stamp);
      verdict_t v;
      // a request noted on this same edge cannot have produced this beat
      if (verdicts.size() == 0 || stamps[0] == stamp) begin
        report("result beat with no request outstanding");
      end else begin
        v = verdicts.pop_front();
        void'(stamps.pop_front());
        if (limited !== v.limited)
          report($sformatf("limited %b, predicted %b", limited, v.limited));
        if (cause !== v.cause)
          report($sformatf("cause %0d, predicted %s", cause, v.cause.name()));
      end
    endtask

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  werl_req_if req_bus ();
  werl_res_if res_bus ();
  werl_cfg_if cfg_bus ();

  windowed_event_rate_limiter DUT (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .res (res_bus),
    .cfg (cfg_bus)
  );

  rate_scoreboard sb = new();

  longint unsigned        t_now;
  logic [WSEC_WIDTH-1:0]  win_len;
  int unsigned            cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready)
      sb.check_result(res_bus.limited, res_bus.cause, $time);
  end

  // receiver stall pattern, independent of the sender
  initial begin
    ready_mode_t mode;
    int          len;
    res_bus.ready = 1'b0;
    forever begin
      mode = ready_mode_t'($urandom_range(0, 3));
      len  = $urandom_range(8, 48);
      for (int k = 0; k < len; k++) begin
        @(posedge clk);
        case (mode)
          RDY_ALWAYS: res_bus.ready <= 1'b1;
          RDY_COIN:   res_bus.ready <= 1'($urandom_range(0, 1));
          RDY_MOSTLY: res_bus.ready <= ($urandom_range(0, 5) != 0);
          default:    res_bus.ready <= (k % 12 == 11);
        endcase
      end
    end
  end

  function longint unsigned add_sat(longint unsigned a, longint unsigned b);
    return (a > 64'(MAX_NOW) - b) ? a : a + b;
  endfunction

  task send_req(input logic [NOW_WIDTH-1:0] now, input logic [ACT_WIDTH-1:0] act,
                input logic [LIMIT_WIDTH-1:0] lim);
    req_bus.valid            <= 1'b1;
    req_bus.now_ns           <= now;
    req_bus.action_id        <= act;
    req_bus.per_action_limit <= lim;
    do @(posedge clk); while (!req_bus.ready);
    sb.note_request(now, act, lim, $time);
  endtask

  task drain();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task write_config(input logic [LIMIT_WIDTH-1:0] ol, input logic [WSEC_WIDTH-1:0] ws);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= CFG_OVERALL_LIMIT;
    cfg_bus.data  <= {1'b0, ol};
    do @(posedge clk); while (!cfg_bus.ready);
    sb.write_reg(CFG_OVERALL_LIMIT, {1'b0, ol});
    cfg_bus.index <= CFG_WINDOW_SECONDS;
    cfg_bus.data  <= ws;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.write_reg(CFG_WINDOW_SECONDS, ws);
    cfg_bus.valid <= 1'b0;
    win_len = ws;
  endtask

  // registers change only with the block idle
  task settle(input logic [LIMIT_WIDTH-1:0] ol, input logic [WSEC_WIDTH-1:0] ws);
    req_bus.valid <= 1'b0;
    drain();
    write_config(ol, ws);
  endtask

  task random_phase(input int count);
    int                     burst_left;
    int                     gap;
    int                     r;
    int                     hot_base;
    longint unsigned        now;
    longint unsigned        span;
    longint unsigned        start;
    logic [ACT_WIDTH-1:0]   act;
    logic [LIMIT_WIDTH-1:0] lim;
    burst_left = 0;
    hot_base   = $urandom_range(0, NUM_ACTIONS_DEF - 1);
    span       = (64'(win_len) + 64'd1) * 64'(NS_PER_SEC);
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          req_bus.valid <= 1'b0;
          if ($urandom_range(0, 9) == 0) drain();
          else repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      r     = $urandom_range(0, 99);
      start = 64'(sb.win_start);
      if (r < 45) begin
        now   = add_sat(t_now, 64'($urandom_range(0, 32'(span / 16))));
        t_now = now;
      end else if (r < 58) begin
        now = t_now;
      end else if (r < 68) begin
        now   = add_sat(t_now, span + 64'($urandom_range(0, 32'(NS_PER_SEC))));
        t_now = now;
      end else if (r < 78) begin
        // one ns short of the restart point, or exactly on it
        now = add_sat(start, span - 64'($urandom_range(0, 1)));
        if (now > t_now) t_now = now;
      end else if (r < 90) begin
        if (start != 0)
          now = start - 64'($urandom_range(1, 32'((start > 64'(NS_PER_SEC)) ?
                                                 64'(NS_PER_SEC) : start)));
        else
          now = t_now;
      end else begin
        now = {$urandom, $urandom} & 64'(MAX_NOW);
        if (now > t_now) t_now = now;
      end
      if ($urandom_range(0, 4) != 0) act = 6'(hot_base + $urandom_range(0, 3));
      else act = 6'($urandom_range(0, NUM_ACTIONS_DEF - 1));
      r = $urandom_range(0, 19);
      if (r < 13) lim = 31'($urandom_range(0, 8));
      else if (r < 16) lim = 31'($urandom);
      else if (r < 18) lim = MAX_LIMIT;
      else lim = '0;
      send_req(now[NOW_WIDTH-1:0], act, lim);
    end
  endtask

  initial begin
    logic [LIMIT_WIDTH-1:0] ol_set [6];
    logic [WSEC_WIDTH-1:0]  ws_set [6];
    logic [LIMIT_WIDTH-1:0] ol;
    logic [WSEC_WIDTH-1:0]  ws;
    ol_set = '{31'd0, 31'd3, MAX_LIMIT, 31'd1, 31'd0, 31'd6};
    ws_set = '{32'd2, 32'd1, 32'd3, 32'd0, 32'd5, 32'd1};

    rst                      = 1'b1;
    req_bus.valid            = 1'b0;
    req_bus.now_ns           = '0;
    req_bus.action_id        = '0;
    req_bus.per_action_limit = '0;
    cfg_bus.valid            = 1'b0;
    cfg_bus.index            = '0;
    cfg_bus.data             = '0;
    win_len                  = DAY_SECONDS;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // default window, overall check off
    send_req('0, 6'd0, 31'd0);
    send_req('0, 6'd63, MAX_LIMIT);
    send_req(T_DAY, 6'd0, 31'd1);
    send_req(T_RST1, 6'd0, 31'd1);
    send_req(T_RST1 - 63'd1, 6'd5, 31'd3);

    // one second window, overall limit of two
    settle(31'd2, 32'd1);
    send_req(T_RST1 + NS_PER_SEC, 6'd1, 31'd5);
    send_req(T_RST1 + NS_PER_SEC + 63'd1, 6'd2, 31'd5);
    send_req(T_RST1 + NS_PER_SEC + 63'd2, 6'd3, 31'd5);
    send_req(T_RST1 + NS_PER_SEC + 63'd3, 6'd1, 31'd1);
    send_req(T_RST2, 6'd4, 31'd5);

    // widest window and overall limit
    settle(MAX_LIMIT, MAX_WINDOW);
    send_req(T_EDGE, 6'd7, MAX_LIMIT);
    send_req(T_RST3, 6'd7, 31'd0);
    send_req(T_RST3 - 63'd1, 6'd9, 31'd0);

    // zero window length
    settle(31'd1, 32'd0);
    send_req(T_RST3 + NS_PER_SEC - 63'd1, 6'd10, 31'd4);
    send_req(T_RST3 + NS_PER_SEC - 63'd1, 6'd11, 31'd4);
    send_req(T_RST3 + NS_PER_SEC, 6'd11, 31'd4);
    send_req(T_RST3 + NS_PER_SEC, 6'd11, 31'h4000_0000);
    send_req(T_RST3 + NS_PER_SEC, 6'd21, 31'h2AAA_AAAA);
    send_req(T_RST3 + NS_PER_SEC, 6'd42, 31'h5555_5555);
    t_now = 64'(T_RST3 + NS_PER_SEC);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p < 6) begin
        ol = ol_set[p];
        ws = ws_set[p];
      end else begin
        ol = 31'($urandom_range(0, 15));
        ws = 32'($urandom_range(0, 4));
      end
      settle(ol, ws);
      random_phase(PHASE_ITEMS);
    end

    send_req(MAX_NOW, 6'd63, MAX_LIMIT);
    req_bus.valid <= 1'b0;
    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
